FILE: hw/rtl/timer_min_heap_lazy_cancel_unit_macros.svh
// Assertion macros used by the timer queue top level.
`ifndef TIMER_MIN_HEAP_LAZY_CANCEL_UNIT_MACROS_SVH
`define TIMER_MIN_HEAP_LAZY_CANCEL_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TMH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed: same-cycle implication");

// Next-cycle implication, checked on every clock edge outside reset.
`define TMH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed: next-cycle implication");

`endif

FILE: hw/rtl/tmh_pkg.sv
// ----------------------------------------------------------------------------
// Timer queue package
// Request and status codes, word types and controller types.
// ----------------------------------------------------------------------------
package tmh_pkg;

    localparam int TIME_W = 63;
    localparam int ID_W   = 6;
    localparam int ID_CNT = 64;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_POP    = 2'd2,
        REQ_QUERY  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } stat_t;

    typedef struct packed {
        logic [TIME_W-1:0] dl;
        logic [ID_W-1:0]   own;
    } entry_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] time_now;
        logic [63:0]       delay;
    } req_word_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            timer_valid;
        logic [ID_W-1:0] timer_out;
        logic [63:0]     next_deadline;
    } rsp_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET,
        S_UP_RD,
        S_UP_CMP,
        S_DR_RD,
        S_DR_TOP,
        S_DR_CHK,
        S_RM_LD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic set_init;
        logic cancel_wr;
        logic rd_par;
        logic up_move;
        logic wr_elem;
        logic rd_top;
        logic lat_top;
        logic rm_start;
        logic lat_elem;
        logic rd_left;
        logic rd_right;
        logic dn_move;
        logic hit;
        logic fin;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic stat_bad;
        logic idx_zero;
        logic count_zero;
        logic par_le;
        logic flag;
        logic due;
        logic l_ge_n;
        logic best_is_e;
        logic out_free;
    } sts_t;

endpackage

FILE: hw/rtl/tmh_ifs.sv
// ----------------------------------------------------------------------------
// Timer queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmh_req_if import tmh_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] time_now;
    logic [63:0]       delay;

    modport source (output valid, req_type, timer_id, time_now, delay, input ready);
    modport sink   (input valid, req_type, timer_id, time_now, delay, output ready);
endinterface

interface tmh_rsp_if import tmh_pkg::*;;
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    logic            timer_valid;
    logic [ID_W-1:0] timer_out;
    logic [63:0]     next_deadline;

    modport source (output valid, status, timer_valid, timer_out, next_deadline,
                    input ready);
    modport sink   (input valid, status, timer_valid, timer_out, next_deadline,
                    output ready);
endinterface

FILE: hw/rtl/tmh_datapath.sv
// ----------------------------------------------------------------------------
// Timer queue datapath
// Heap and cancel-flag memories, sift registers and the response register.
// ----------------------------------------------------------------------------
module tmh_datapath import tmh_pkg::*; #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  req_word_t in_word,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      out_valid,
    input  logic      out_ready,
    output rsp_word_t out_word
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    entry_t heap_mem [HEAP_DEPTH];
    logic   cancel_mem [ID_CNT];

    req_word_t word_reg;
    stat_t     stat_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    entry_t    elem_reg, top_reg, lft_reg, rd_reg;
    logic      flag_rd_reg;
    logic      hit_reg;
    logic      out_valid_reg;
    rsp_word_t out_word_reg;

    logic [AW:0]   left, right;
    logic [AW-1:0] parent;
    logic          r_lt_n, best_l, best_r;
    logic [TIME_W-1:0] best_dl;
    logic [63:0]   sum;
    logic [TIME_W-1:0] new_dl;
    stat_t         stat_in;
    logic          mem_re, mem_we;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        wr_data;
    rsp_word_t     res;

    assign left   = {idx_reg, 1'b1};
    assign right  = left + (AW+1)'(1);
    assign parent = AW'((idx_reg - AW'(1)) >> 1);
    assign r_lt_n = (AW+2)'(right) < (AW+2)'(count_reg);
    assign best_l = lft_reg.dl < elem_reg.dl;
    assign best_dl = best_l ? lft_reg.dl : elem_reg.dl;
    assign best_r = r_lt_n && (rd_reg.dl < best_dl);

    // Delay is known non-negative here, so its low 63 bits are the value.
    assign sum    = {1'b0, word_reg.time_now} + {1'b0, word_reg.delay[62:0]};
    assign new_dl = sum[63] ? '1 : sum[TIME_W-1:0];

    always_comb
    begin
        stat_in = ST_OK;
        if (req_t'(in_word.req_type) == REQ_SET)
        begin
            if (in_word.delay[63])
                stat_in = ST_INVALID;
            else if (count_reg == CW'(HEAP_DEPTH))
                stat_in = ST_FULL;
        end
    end

    always_comb
    begin
        mem_re  = cmd.rd_par | cmd.rd_top | cmd.rm_start | cmd.rd_left | cmd.rd_right;
        rd_addr = '0;
        if (cmd.rd_par)
            rd_addr = parent;
        else if (cmd.rm_start)
            rd_addr = AW'(count_reg - CW'(1));
        else if (cmd.rd_left)
            rd_addr = left[AW-1:0];
        else if (cmd.rd_right)
            rd_addr = right[AW-1:0];
        mem_we  = cmd.wr_elem | cmd.up_move | cmd.dn_move;
        wr_addr = idx_reg;
        wr_data = elem_reg;
        if (cmd.up_move)
            wr_data = rd_reg;
        else if (cmd.dn_move)
            wr_data = best_r ? rd_reg : lft_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            heap_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_reg <= heap_mem[rd_addr];
        if (cmd.set_init || cmd.cancel_wr)
            cancel_mem[word_reg.timer_id] <= cmd.cancel_wr;
        if (cmd.lat_top)
            flag_rd_reg <= cancel_mem[rd_reg.own];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            word_reg <= in_word;
            stat_reg <= stat_in;
        end
        if (cmd.set_init)
            elem_reg <= '{dl: new_dl, own: word_reg.timer_id};
        else if (cmd.lat_elem)
            elem_reg <= rd_reg;
        if (cmd.set_init)
            idx_reg <= AW'(count_reg);
        else if (cmd.rm_start)
            idx_reg <= '0;
        else if (cmd.up_move)
            idx_reg <= parent;
        else if (cmd.dn_move)
            idx_reg <= best_r ? right[AW-1:0] : left[AW-1:0];
        if (cmd.lat_top)
            top_reg <= rd_reg;
        if (cmd.rd_right)
            lft_reg <= rd_reg;
        if (cmd.fin)
            out_word_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_init)
                count_reg <= count_reg + CW'(1);
            else if (cmd.rm_start)
                count_reg <= count_reg - CW'(1);
            if (cmd.start)
                hit_reg <= 1'b0;
            else if (cmd.set_init || cmd.hit)
                hit_reg <= 1'b1;
            if (cmd.fin)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        res.status      = stat_reg;
        res.timer_valid = hit_reg;
        res.timer_out   = '0;
        if (hit_reg)
            res.timer_out = (req_t'(word_reg.req_type) == REQ_SET) ? word_reg.timer_id
                                                                   : top_reg.own;
        res.next_deadline = '0;
        if (req_t'(word_reg.req_type) == REQ_QUERY)
            res.next_deadline = (count_reg == '0) ? '1 : {1'b0, top_reg.dl};
    end

    assign sts.req        = req_t'(word_reg.req_type);
    assign sts.stat_bad   = stat_reg != ST_OK;
    assign sts.idx_zero   = idx_reg == '0;
    assign sts.count_zero = count_reg == '0;
    assign sts.par_le     = rd_reg.dl <= elem_reg.dl;
    assign sts.flag       = flag_rd_reg;
    assign sts.due        = top_reg.dl <= word_reg.time_now;
    assign sts.l_ge_n     = (AW+2)'(left) >= (AW+2)'(count_reg);
    assign sts.best_is_e  = !best_l && !best_r;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: hw/rtl/tmh_ctrl.sv
// ----------------------------------------------------------------------------
// Timer queue controller
// Sequences push, drain, extract and sift steps over the datapath.
// ----------------------------------------------------------------------------
module tmh_ctrl import tmh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   ret_fin_reg, ret_fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_fin_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_fin_reg <= ret_fin_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        ret_fin_next = ret_fin_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SET;
            S_SET:
                if (sts.stat_bad || sts.req == REQ_CANCEL)
                    state_next = S_FIN;
                else if (sts.req == REQ_SET)
                    state_next = S_UP_RD;
                else
                    state_next = S_DR_RD;
            S_UP_RD:
                state_next = sts.idx_zero ? S_FIN : S_UP_CMP;
            S_UP_CMP:
                state_next = sts.par_le ? S_FIN : S_UP_RD;
            S_DR_RD:
                state_next = sts.count_zero ? S_FIN : S_DR_TOP;
            S_DR_TOP:
                state_next = S_DR_CHK;
            S_DR_CHK:
                if (sts.flag)
                begin
                    ret_fin_next = 1'b0;
                    state_next   = S_RM_LD;
                end
                else if (sts.req == REQ_POP && sts.due)
                begin
                    ret_fin_next = 1'b1;
                    state_next   = S_RM_LD;
                end
                else
                    state_next = S_FIN;
            S_RM_LD:
                if (sts.count_zero)
                    state_next = ret_fin_reg ? S_FIN : S_DR_RD;
                else
                    state_next = S_DN_RDL;
            S_DN_RDL:
                if (sts.l_ge_n)
                    state_next = ret_fin_reg ? S_FIN : S_DR_RD;
                else
                    state_next = S_DN_RDR;
            S_DN_RDR:
                state_next = S_DN_CMP;
            S_DN_CMP:
                if (sts.best_is_e)
                    state_next = ret_fin_reg ? S_FIN : S_DR_RD;
                else
                    state_next = S_DN_RDL;
            S_FIN:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
                cmd.start = in_valid;
            S_SET:
                if (!sts.stat_bad)
                begin
                    cmd.set_init  = sts.req == REQ_SET;
                    cmd.cancel_wr = sts.req == REQ_CANCEL;
                end
            S_UP_RD:
                if (sts.idx_zero)
                    cmd.wr_elem = 1'b1;
                else
                    cmd.rd_par = 1'b1;
            S_UP_CMP:
                if (sts.par_le)
                    cmd.wr_elem = 1'b1;
                else
                    cmd.up_move = 1'b1;
            S_DR_RD:
                cmd.rd_top = !sts.count_zero;
            S_DR_TOP:
                cmd.lat_top = 1'b1;
            S_DR_CHK:
                if (sts.flag)
                    cmd.rm_start = 1'b1;
                else if (sts.req == REQ_POP && sts.due)
                begin
                    cmd.rm_start = 1'b1;
                    cmd.hit      = 1'b1;
                end
            S_RM_LD:
                cmd.lat_elem = !sts.count_zero;
            S_DN_RDL:
                if (sts.l_ge_n)
                    cmd.wr_elem = 1'b1;
                else
                    cmd.rd_left = 1'b1;
            S_DN_RDR:
                cmd.rd_right = 1'b1;
            S_DN_CMP:
                if (sts.best_is_e)
                    cmd.wr_elem = 1'b1;
                else
                    cmd.dn_move = 1'b1;
            S_FIN:
                cmd.fin = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/timer_min_heap_lazy_cancel_unit.sv
// ----------------------------------------------------------------------------
// Timer min-heap queue with lazy cancel
// Cancel writes its flag and responds. Set places the new entry at the next
// free slot and climbs, reading one parent per level. Pop and query first
// drain cancelled tops; each top removed moves the last entry to the root
// and walks it down, reading its children per level. One word at
// a time, through a single registered read port. Reset clears the entry count
// and the FSM; heap and cancel-flag memories are not cleared.
// ----------------------------------------------------------------------------
`include "timer_min_heap_lazy_cancel_unit_macros.svh"

module timer_min_heap_lazy_cancel_unit import tmh_pkg::*; #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    tmh_req_if.sink   req,
    tmh_rsp_if.source rsp
);

    cmd_t      cmd;
    sts_t      sts;
    req_word_t in_word;
    rsp_word_t out_word;
    logic      in_ready;

    assign in_word.req_type = req.req_type;
    assign in_word.timer_id = req.timer_id;
    assign in_word.time_now = req.time_now;
    assign in_word.delay    = req.delay;
    assign req.ready        = in_ready;

    tmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmh_datapath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_word  (out_word)
    );

    assign rsp.status        = out_word.status;
    assign rsp.timer_valid   = out_word.timer_valid;
    assign rsp.timer_out     = out_word.timer_out;
    assign rsp.next_deadline = out_word.next_deadline;

    `TMH_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, !req.ready)
    `TMH_ASSERT_IMPL(a_fin_free, cmd.fin, !rsp.valid || rsp.ready)
    `TMH_ASSERT_IMPL(a_one_write, 1'b1, $countones({cmd.wr_elem, cmd.up_move, cmd.dn_move}) <= 1)

endmodule

FILE: bench/tb_timer_min_heap_lazy_cancel_unit.sv
// ----------------------------------------------------------------------------
// Timer queue testbench
// Drives set, cancel, pop and query words into the timer heap and checks
// every response word against a behavioral heap kept in the bench. Covers
// the special cases directly, fills the heap to overflow, applies long
// response back-pressure and then runs random traffic under three idle mixes.
// ----------------------------------------------------------------------------
module tb_timer_min_heap_lazy_cancel_unit;
    import tmh_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

    logic clk;
    logic rst_n;

    tmh_req_if req ();
    tmh_rsp_if rsp ();

    timer_min_heap_lazy_cancel_unit #(.HEAP_DEPTH(DEPTH)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Heap state as the bench sees it.
    logic [TIME_W-1:0] heap_dl [DEPTH];
    logic [ID_W-1:0]   heap_id [DEPTH];
    int                heap_count;
    logic              cancelled [ID_CNT];

    rsp_word_t pending_rsp [$];
    int  errors;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_left;
    logic [TIME_W-1:0] clock_ns;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void swap_slots(int a, int b);
        logic [TIME_W-1:0] d;
        logic [ID_W-1:0]   o;
        d = heap_dl[a];
        o = heap_id[a];
        heap_dl[a] = heap_dl[b];
        heap_id[a] = heap_id[b];
        heap_dl[b] = d;
        heap_id[b] = o;
    endfunction

    function automatic void remove_top();
        int i;
        int l;
        int r;
        int best;
        if (heap_count == 0)
            return;
        heap_count--;
        if (heap_count == 0)
            return;
        heap_dl[0] = heap_dl[heap_count];
        heap_id[0] = heap_id[heap_count];
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            best = i;
            if (l < heap_count && heap_dl[l] < heap_dl[best])
                best = l;
            if (r < heap_count && heap_dl[r] < heap_dl[best])
                best = r;
            if (best == i)
                break;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    function automatic void drop_cancelled_tops();
        while (heap_count > 0 && cancelled[heap_id[0]])
            remove_top();
    endfunction

    function automatic rsp_word_t heap_response(req_t kind, logic [ID_W-1:0] id,
                                                logic [TIME_W-1:0] now,
                                                logic [63:0] dly);
        rsp_word_t w;
        logic [63:0] sum;
        int i;
        int p;
        w = '0;
        w.status = ST_OK;
        case (kind)
            REQ_SET:
            begin
                if (dly[63])
                    w.status = ST_INVALID;
                else if (heap_count >= DEPTH)
                    w.status = ST_FULL;
                else
                begin
                    sum = {1'b0, now} + dly;
                    heap_dl[heap_count] = sum[63] ? TIME_TOP : sum[TIME_W-1:0];
                    heap_id[heap_count] = id;
                    i = heap_count;
                    heap_count++;
                    while (i > 0)
                    begin
                        p = (i - 1) / 2;
                        if (heap_dl[p] <= heap_dl[i])
                            break;
                        swap_slots(p, i);
                        i = p;
                    end
                    cancelled[id] = 1'b0;
                    w.timer_valid = 1'b1;
                    w.timer_out = id;
                end
            end
            REQ_CANCEL:
                cancelled[id] = 1'b1;
            REQ_POP:
            begin
                drop_cancelled_tops();
                if (heap_count > 0 && heap_dl[0] <= now)
                begin
                    w.timer_valid = 1'b1;
                    w.timer_out = heap_id[0];
                    remove_top();
                end
            end
            default:
            begin
                drop_cancelled_tops();
                w.next_deadline = (heap_count == 0) ? '1 : {1'b0, heap_dl[0]};
            end
        endcase
        return w;
    endfunction

    task automatic send_word(req_t kind, logic [ID_W-1:0] id,
                             logic [TIME_W-1:0] now, logic [63:0] dly);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.timer_id <= id;
        req.time_now <= now;
        req.delay    <= dly;
        do
            @(posedge clk);
        while (!req.ready);
        pending_rsp.push_back(heap_response(kind, id, now, dly));
    endtask

    // Lowers valid and waits until every response is back and the block idles.
    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        rsp_word_t exp_w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with nothing expected");
                errors++;
            end
            else
            begin
                exp_w = pending_rsp.pop_front();
                if (rsp.status !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, rsp.status);
                    errors++;
                end
                if (rsp.timer_valid !== exp_w.timer_valid)
                begin
                    $error("timer_valid: expected %0d, got %0d",
                           exp_w.timer_valid, rsp.timer_valid);
                    errors++;
                end
                if (rsp.timer_out !== exp_w.timer_out)
                begin
                    $error("timer_out: expected %0d, got %0d",
                           exp_w.timer_out, rsp.timer_out);
                    errors++;
                end
                if (rsp.next_deadline !== exp_w.next_deadline)
                begin
                    $error("next_deadline: expected %0h, got %0h",
                           exp_w.next_deadline, rsp.next_deadline);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_timer_min_heap_lazy_cancel_unit NOT OK");
            $finish;
        end
    end

    task automatic test_special_cases();
        send_word(REQ_QUERY, 0, 0, 0);
        send_word(REQ_POP, 0, TIME_TOP, 0);
        send_word(REQ_SET, 0, 100, 0);
        send_word(REQ_SET, 1, 100, '1);
        send_word(REQ_SET, 7, 5, 64'h8000_0000_0000_0000);
        send_word(REQ_SET, 63, TIME_TOP, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(REQ_SET, 2, 0, 50);
        send_word(REQ_QUERY, 0, 0, 0);
        send_word(REQ_POP, 0, 49, 0);
        send_word(REQ_POP, 0, 50, 0);
        send_word(REQ_CANCEL, 0, 0, 0);
        send_word(REQ_QUERY, 0, 0, 0);
        send_word(REQ_SET, 5, 0, 10);
        send_word(REQ_CANCEL, 5, 0, 0);
        send_word(REQ_SET, 5, 0, 20);
        send_word(REQ_POP, 0, 30, 0);
        send_word(REQ_POP, 0, 30, 0);
        send_word(REQ_CANCEL, 40, 0, 0);
        send_word(REQ_SET, 9, 1000, 0);
        send_word(REQ_CANCEL, 9, 0, 0);
        send_word(REQ_POP, 0, TIME_TOP, 0);
        send_word(REQ_POP, 0, TIME_TOP, 0);
        send_word(REQ_QUERY, 0, 0, 0);
        drain();
    endtask

    // Fills the heap past its depth; the last sets must report full.
    task automatic test_heap_full();
        int k;
        for (k = 0; k < DEPTH + 2; k++)
            send_word(REQ_SET, ID_W'($urandom_range(0, 63)), TIME_W'(k),
                      64'($urandom_range(0, 500)));
        send_word(REQ_QUERY, 0, 0, 0);
        drain();
    endtask

    // Responses are held back while requests keep coming, so the block stalls.
    task automatic test_backpressure();
        int k;
        hold_left = 400;
        for (k = 0; k < 40; k++)
            send_word(REQ_POP, 0, TIME_TOP, 0);
        drain();
    endtask

    task automatic random_word();
        int pick;
        logic [TIME_W-1:0] now;
        logic [63:0] dly;
        pick = $urandom_range(0, 99);
        clock_ns = clock_ns + TIME_W'($urandom_range(0, 300));
        now = clock_ns;
        if ($urandom_range(0, 49) == 0)
            now = TIME_W'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0: dly = {$urandom, $urandom};
            1: dly = {1'b0, 31'($urandom), 32'($urandom)};
            default: dly = 64'($urandom_range(0, 2000));
        endcase
        if (pick < 40)
            send_word(REQ_SET, ID_W'($urandom_range(0, 63)), now, dly);
        else if (pick < 55)
            send_word(REQ_CANCEL, ID_W'($urandom_range(0, 63)), now, dly);
        else if (pick < 85)
            send_word(REQ_POP, ID_W'($urandom), now, dly);
        else
            send_word(REQ_QUERY, ID_W'($urandom), now, dly);
    endtask

    task automatic test_random_traffic(int count, int s_idle, int r_idle);
        int k;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (k = 0; k < count; k++)
            random_word();
        drain();
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        errors = 0;
        cycle_count = 0;
        hold_left = 0;
        heap_count = 0;
        clock_ns = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < ID_CNT; k++)
            cancelled[k] = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_SET;
        req.timer_id = '0;
        req.time_now = '0;
        req.delay = '0;
        rsp.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_heap_full();
        test_backpressure();
        test_random_traffic(520, 21, 87);
        test_random_traffic(520, 87, 21);
        test_random_traffic(520, 0, 0);

        if (errors == 0)
            $display("tb_timer_min_heap_lazy_cancel_unit OK");
        else
            $display("tb_timer_min_heap_lazy_cancel_unit NOT OK");
        $finish;
    end
endmodule
